[hw/rtl/bdar_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdar_pkg
// Shared types and constants for the button debouncer with auto-repeat.
// ----------------------------------------------------------------------------
package bdar_pkg;

  localparam int TIME_BITS = 32;
  localparam int CFG_BITS  = 16;
  localparam int NOW_BITS  = 32;

  typedef logic [TIME_BITS-1:0] time_val_t;
  typedef logic [CFG_BITS-1:0]  cfg_val_t;

  // Item kinds carried on s_tuser.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_INIT   = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_DEBOUNCE_TIME   = 2'd0,
    REG_HOLD_DELAY      = 2'd1,
    REG_REPEAT_INTERVAL = 2'd2
  } reg_index_t;

  localparam cfg_val_t DEBOUNCE_TIME_RST   = 16'd35;
  localparam cfg_val_t HOLD_DELAY_RST      = 16'd450;
  localparam cfg_val_t REPEAT_INTERVAL_RST = 16'd140;

  typedef struct packed {
    cfg_val_t debounce_time;
    cfg_val_t hold_delay;
    cfg_val_t repeat_interval;
  } bdar_cfg_t;

  typedef struct packed {
    logic      raw_level;
    logic      stable_level;
    logic      repeating;
    time_val_t edge_time;
    time_val_t press_time;
    time_val_t repeat_time;
  } bdar_state_t;

  typedef struct packed {
    logic repeat_ev;
    logic release_ev;
    logic press_ev;
  } bdar_events_t;

endpackage

[hw/rtl/button_debounce_autorepeat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_autorepeat
// Debounces a sampled button level against a millisecond timestamp and gives
// press, release and auto-repeat events, one result item per input item.
// ----------------------------------------------------------------------------
// Dataflow: an accepted item sits in the input register, then the step logic
// loads the result and state registers together.
// Throughput: one item per cycle unless the result side stalls (m_tready low).
// Reset: synchronous rst clears the debounce state and loads the default
// timing registers (35, 450, 140 ms); no clearing pass is needed.
module button_debounce_autorepeat import bdar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [0] button_level, [32:1] now_time, [39:33] zero
  input  logic        s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] press_event, [1] release_event,
                                 // [2] repeat_event, [7:3] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  bdar_cfg_t           cfg;
  bdar_state_t         state;
  bdar_state_t         state_next;
  bdar_events_t        events;
  logic                in_valid;
  logic                in_opcode;
  logic                in_level;
  logic [NOW_BITS-1:0] in_time;
  logic                advance;
  bdar_events_t        out_events;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time   <= DEBOUNCE_TIME_RST;
      cfg.hold_delay      <= HOLD_DELAY_RST;
      cfg.repeat_interval <= REPEAT_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE_TIME:   cfg.debounce_time   <= cfg_wdata;
        REG_HOLD_DELAY:      cfg.hold_delay      <= cfg_wdata;
        REG_REPEAT_INTERVAL: cfg.repeat_interval <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_opcode <= s_tuser;
      in_level  <= s_tdata[0];
      in_time   <= s_tdata[NOW_BITS:1];
    end
  end

  bdar_step u_step (
    .cfg          (cfg),
    .state        (state),
    .opcode       (in_opcode),
    .button_level (in_level),
    .now_time     (in_time),
    .state_next   (state_next),
    .events       (events)
  );

  // State and result register update together as an item leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (advance) begin
      out_events <= events;
    end
  end

  assign m_tdata = {5'd0, out_events.repeat_ev, out_events.release_ev, out_events.press_ev};

`ifndef SYNTHESIS
  a_no_press_and_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_events.press_ev && out_events.release_ev))
    else $error("press and release in the same item");

  a_repeat_needs_press: assert property (@(posedge clk) disable iff (rst)
    state.repeating |-> state.stable_level)
    else $error("repeating while the stable level is released");

  a_repeat_state: assert property (@(posedge clk) disable iff (rst)
    (advance && events.repeat_ev) |=> (state.stable_level && state.repeating))
    else $error("repeat event without a held, repeating button");

  a_release_state: assert property (@(posedge clk) disable iff (rst)
    (advance && events.release_ev) |=> (!state.stable_level && !state.repeating))
    else $error("release event left the button pressed");
`endif

endmodule

[hw/rtl/bdar_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdar_step
// Next-state and event logic for one item: debounce check, press/release
// detection and the hold / auto-repeat timers.
// ----------------------------------------------------------------------------
module bdar_step import bdar_pkg::*; (
  input  bdar_cfg_t           cfg,
  input  bdar_state_t         state,
  input  logic                opcode,
  input  logic                button_level,
  input  logic [NOW_BITS-1:0] now_time,
  output bdar_state_t         state_next,
  output bdar_events_t        events
);

  time_val_t   now;
  time_val_t   edge_n;
  time_val_t   press_n;
  time_val_t   rep_base;
  logic        change;
  logic        rep_cur;
  logic        stable_n;
  logic        hold_hit;
  logic        intv_hit;

  assign now = time_val_t'(now_time);

  always_comb begin
    edge_n   = (button_level != state.raw_level) ? now : state.edge_time;
    // Stable level follows once the raw level has been steady long enough.
    change   = ((now - edge_n) >= time_val_t'(cfg.debounce_time)) &&
               (state.stable_level != button_level);
    stable_n = change ? button_level : state.stable_level;
    rep_cur  = change ? 1'b0 : state.repeating;
    press_n  = (change && button_level) ? now : state.press_time;
    rep_base = (change && button_level) ? now : state.repeat_time;
    hold_hit = (now - press_n) >= time_val_t'(cfg.hold_delay);
    intv_hit = (now - rep_base) >= time_val_t'(cfg.repeat_interval);

    state_next.raw_level    = button_level;
    state_next.stable_level = stable_n;
    state_next.repeating    = rep_cur;
    state_next.edge_time    = edge_n;
    state_next.press_time   = press_n;
    state_next.repeat_time  = rep_base;

    events.press_ev   = change && button_level;
    events.release_ev = change && !button_level;
    events.repeat_ev  = 1'b0;

    if (stable_n) begin
      if (!rep_cur && hold_hit) begin
        state_next.repeating   = 1'b1;
        state_next.repeat_time = now;
        events.repeat_ev       = 1'b1;
      end else if (rep_cur && intv_hit) begin
        state_next.repeat_time = now;
        events.repeat_ev       = 1'b1;
      end
    end

    if (opcode == OP_INIT) begin
      state_next.raw_level    = button_level;
      state_next.stable_level = button_level;
      state_next.repeating    = 1'b0;
      state_next.edge_time    = now;
      state_next.press_time   = now;
      state_next.repeat_time  = now;
      events                  = '0;
    end
  end

endmodule

[verif/button_debounce_autorepeat_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_test
// Self-checking bench for the button debouncer. A directed table covers reset
// timing, timestamp wrap and the zero and full-scale timing registers. Random
// phases then drive bouncing press and release sequences under a range of
// register settings. Each result item is checked against its table entry or a
// built-in debounce and auto-repeat predictor, with random idling on both streams.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat_test;
  import bdar_pkg::*;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int NUM_PHASES       = 12;
  localparam int ITEMS_PER_PHASE  = 120;
  localparam int DRAIN_CYCLES     = 10;
  localparam int MAX_PRINTED      = 30;

  localparam bdar_events_t EV_NONE         = '{repeat_ev: 1'b0, release_ev: 1'b0, press_ev: 1'b0};
  localparam bdar_events_t EV_PRESS        = '{repeat_ev: 1'b0, release_ev: 1'b0, press_ev: 1'b1};
  localparam bdar_events_t EV_RELEASE      = '{repeat_ev: 1'b0, release_ev: 1'b1, press_ev: 1'b0};
  localparam bdar_events_t EV_REPEAT       = '{repeat_ev: 1'b1, release_ev: 1'b0, press_ev: 1'b0};
  localparam bdar_events_t EV_PRESS_REPEAT = '{repeat_ev: 1'b1, release_ev: 1'b0, press_ev: 1'b1};

  typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic         op;
    logic         level;
    time_val_t    stamp;
    bit           typed;
    bdar_events_t want;
    reg_index_t   idx;
    cfg_val_t     val;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;   // [0] button_level, [32:1] now_time, [39:33] zero
  logic        s_tuser   = OP_UPDATE;   // [0] opcode
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;   // [0] press_event, [1] release_event, [2] repeat_event
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_addr  = REG_DEBOUNCE_TIME;
  logic [15:0] cfg_wdata = '0;

  // Predictor copy of the timing registers and the debounce state.
  cfg_val_t  debounce_ms = DEBOUNCE_TIME_RST;
  cfg_val_t  hold_ms     = HOLD_DELAY_RST;
  cfg_val_t  interval_ms = REPEAT_INTERVAL_RST;
  logic      btn_raw       = 1'b0;
  logic      btn_stable    = 1'b0;
  logic      btn_repeating = 1'b0;
  time_val_t t_edge        = '0;
  time_val_t t_press       = '0;
  time_val_t t_repeat      = '0;

  bdar_events_t pending_events[$];
  dir_row_t     dir_table[$];
  int           mismatches  = 0;
  int           cycle_count = 0;
  int           ready_hold  = 0;
  bit           calm        = 1'b0;

  button_debounce_autorepeat i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Advances the debounce state by one item and returns the events it gives.
  function automatic bdar_events_t predict_step(logic op, logic level, time_val_t stamp);
    bdar_events_t ev;
    time_val_t    since_edge;
    time_val_t    since_press;
    time_val_t    since_repeat;
    ev = EV_NONE;
    if (op == OP_INIT) begin
      btn_raw       = level;
      btn_stable    = level;
      btn_repeating = 1'b0;
      t_edge        = stamp;
      t_press       = stamp;
      t_repeat      = stamp;
    end else begin
      if (level != btn_raw) begin
        btn_raw = level;
        t_edge  = stamp;
      end
      since_edge = stamp - t_edge;
      if (since_edge >= time_val_t'(debounce_ms) && btn_stable != btn_raw) begin
        btn_stable    = btn_raw;
        btn_repeating = 1'b0;
        if (btn_stable) begin
          t_press     = stamp;
          t_repeat    = stamp;
          ev.press_ev = 1'b1;
        end else begin
          ev.release_ev = 1'b1;
        end
      end
      if (btn_stable) begin
        since_press  = stamp - t_press;
        since_repeat = stamp - t_repeat;
        if (!btn_repeating && since_press >= time_val_t'(hold_ms)) begin
          btn_repeating = 1'b1;
          t_repeat      = stamp;
          ev.repeat_ev  = 1'b1;
        end else if (btn_repeating && since_repeat >= time_val_t'(interval_ms)) begin
          t_repeat     = stamp;
          ev.repeat_ev = 1'b1;
        end
      end
    end
    return ev;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic send_item(logic op, logic level, time_val_t stamp, bit typed,
                           bdar_events_t want);
    int           gap;
    bdar_events_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'b0, stamp, level};
    do @(posedge clk); while (!s_tready);
    predicted = predict_step(op, level, stamp);
    pending_events.push_back(typed ? want : predicted);
  endtask

  // Holds the sender off until every pending result item has arrived.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, cfg_val_t val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE_TIME:   debounce_ms = val;
      REG_HOLD_DELAY:      hold_ms     = val;
      REG_REPEAT_INTERVAL: interval_ms = val;
      default: ;
    endcase
  endtask

  function automatic void add_item(logic op, logic level, time_val_t stamp, bit typed,
                                   bdar_events_t want);
    dir_row_t row;
    row.kind  = ROW_ITEM;
    row.op    = op;
    row.level = level;
    row.stamp = stamp;
    row.typed = typed;
    row.want  = want;
    row.idx   = REG_DEBOUNCE_TIME;
    row.val   = '0;
    dir_table.push_back(row);
  endfunction

  function automatic void add_reg(reg_index_t idx, cfg_val_t val);
    dir_row_t row;
    row.kind  = ROW_REG;
    row.op    = OP_UPDATE;
    row.level = 1'b0;
    row.stamp = '0;
    row.typed = 1'b0;
    row.want  = EV_NONE;
    row.idx   = idx;
    row.val   = val;
    dir_table.push_back(row);
  endfunction

  // Result side: random stalls, with calm stretches of steady readiness.
  always @(posedge clk) begin
    int r;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (calm) begin
      m_tready   <= 1'b1;
      ready_hold <= $urandom_range(0, 7);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        m_tready   <= 1'b1;
        ready_hold <= $urandom_range(0, 7);
      end else if (r < 85) begin
        m_tready   <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else if (r < 97) begin
        m_tready   <= 1'b0;
        ready_hold <= $urandom_range(3, 10);
      end else begin
        m_tready   <= 1'b0;
        ready_hold <= $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk) begin
    bdar_events_t got;
    bdar_events_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = bdar_events_t'(m_tdata[2:0]);
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result item %b", m_tdata));
      end else begin
        want = pending_events.pop_front();
        if (got.press_ev != want.press_ev)
          report_mismatch($sformatf("press_event %b, expected %b", got.press_ev,
                                    want.press_ev));
        if (got.release_ev != want.release_ev)
          report_mismatch($sformatf("release_event %b, expected %b", got.release_ev,
                                    want.release_ev));
        if (got.repeat_ev != want.repeat_ev)
          report_mismatch($sformatf("repeat_event %b, expected %b", got.repeat_ev,
                                    want.repeat_ev));
      end
    end
  end

  initial begin
    time_val_t stamp;
    logic      target;
    logic      level;
    logic      op;
    int        r;
    int        max_step;
    cfg_val_t  deb;
    cfg_val_t  hold;
    cfg_val_t  intv;

    // Reset timing: press, first repeat, a later repeat and release.
    add_item(OP_INIT,   1'b0, 32'd0,   1'b1, EV_NONE);
    add_item(OP_UPDATE, 1'b1, 32'd10,  1'b1, EV_NONE);
    add_item(OP_UPDATE, 1'b1, 32'd45,  1'b1, EV_PRESS);
    add_item(OP_UPDATE, 1'b1, 32'd495, 1'b1, EV_REPEAT);
    add_item(OP_UPDATE, 1'b1, 32'd634, 1'b1, EV_NONE);
    add_item(OP_UPDATE, 1'b1, 32'd635, 1'b1, EV_REPEAT);
    add_item(OP_UPDATE, 1'b0, 32'd700, 1'b1, EV_NONE);
    add_item(OP_UPDATE, 1'b0, 32'd735, 1'b1, EV_RELEASE);
    // Hold delay measured across the timestamp wrap.
    add_item(OP_INIT,   1'b1, 32'hFFFF_FFF0, 1'b1, EV_NONE);
    add_item(OP_UPDATE, 1'b1, 32'h0000_01B2, 1'b1, EV_REPEAT);
    add_item(OP_UPDATE, 1'b0, 32'hFFFF_FFFF, 1'b0, EV_NONE);
    // Zero debounce and zero hold: press and first repeat in one item.
    add_reg(REG_DEBOUNCE_TIME,   16'd0);
    add_reg(REG_HOLD_DELAY,      16'd0);
    add_reg(REG_REPEAT_INTERVAL, 16'hFFFF);
    add_item(OP_INIT,   1'b0, 32'd100, 1'b1, EV_NONE);
    add_item(OP_UPDATE, 1'b1, 32'd100, 1'b1, EV_PRESS_REPEAT);
    add_item(OP_UPDATE, 1'b1, 32'd101, 1'b1, EV_NONE);
    add_item(OP_UPDATE, 1'b0, 32'd102, 1'b1, EV_RELEASE);
    // Full-scale debounce and hold, zero repeat interval.
    add_reg(REG_DEBOUNCE_TIME,   16'hFFFF);
    add_reg(REG_HOLD_DELAY,      16'hFFFF);
    add_reg(REG_REPEAT_INTERVAL, 16'd0);
    add_item(OP_INIT,   1'b0, 32'd0,      1'b1, EV_NONE);
    add_item(OP_UPDATE, 1'b1, 32'd0,      1'b1, EV_NONE);
    add_item(OP_UPDATE, 1'b1, 32'd65534,  1'b1, EV_NONE);
    add_item(OP_UPDATE, 1'b1, 32'd65535,  1'b1, EV_PRESS);
    add_item(OP_UPDATE, 1'b1, 32'd131070, 1'b1, EV_REPEAT);
    add_item(OP_UPDATE, 1'b1, 32'd131070, 1'b1, EV_REPEAT);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_REG) begin
        drain_results();
        write_reg(dir_table[i].idx, dir_table[i].val);
      end else begin
        send_item(dir_table[i].op, dir_table[i].level, dir_table[i].stamp,
                  dir_table[i].typed, dir_table[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case (p % 6)
        0: begin
          deb  = '0;
          hold = '0;
          intv = '0;
        end
        1: begin
          deb  = 16'hFFFF;
          hold = 16'hFFFF;
          intv = 16'hFFFF;
        end
        default: begin
          deb  = cfg_val_t'($urandom_range(0, 20));
          hold = cfg_val_t'($urandom_range(0, 80));
          intv = cfg_val_t'($urandom_range(0, 40));
          if ($urandom_range(0, 3) == 0) hold = cfg_val_t'($urandom_range(0, 16'hFFFF));
        end
      endcase
      write_reg(REG_DEBOUNCE_TIME,   deb);
      write_reg(REG_HOLD_DELAY,      hold);
      write_reg(REG_REPEAT_INTERVAL, intv);
      calm = (p % 4 == 3);

      max_step = int'(deb);
      if (int'(hold) > max_step) max_step = int'(hold);
      if (int'(intv) > max_step) max_step = int'(intv);
      max_step = max_step / 4 + 3;

      stamp  = $urandom;
      target = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) != 0) send_item(OP_INIT, target, stamp, 1'b0, EV_NONE);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 6) stamp = $urandom;
        else stamp = stamp + $urandom_range(0, max_step);
        op = (r < 3) ? OP_INIT : OP_UPDATE;
        if ($urandom_range(0, 99) < 8) target = ~target;
        // Contact bounce: the raw level briefly shows the other state.
        level = ($urandom_range(0, 99) < 15) ? ~target : target;
        send_item(op, level, stamp, 1'b0, EV_NONE);
        if (p == 2 && k == ITEMS_PER_PHASE / 2) drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bdar_pkg.sv
hw/rtl/bdar_step.sv
hw/rtl/button_debounce_autorepeat.sv
verif/button_debounce_autorepeat_test.sv
